// ===== hw/rtl/hall_sensor_angle_minmax_tracker_macros.svh =====
// Assertion shorthands for the angle tracker. Both expect clk and rst_n in scope.
`ifndef HALL_SENSOR_ANGLE_MINMAX_TRACKER_MACROS_SVH
`define HALL_SENSOR_ANGLE_MINMAX_TRACKER_MACROS_SVH

// Same-cycle implication
`define HSAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HSAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hsat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsat_pkg;

  localparam int COEF_W   = 48;
  localparam int ANGLE_W  = 24;
  localparam int MAX_CH_W = 6;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef enum logic [1:0] {
    REQ_CONVERT = 2'd0,
    REQ_CLEAR   = 2'd1,
    REQ_WRITE   = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  localparam logic [1:0] SLOT_SQ  = 2'd0;
  localparam logic [1:0] SLOT_LIN = 2'd1;
  localparam logic [1:0] SLOT_OFS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LDA,
    ST_LDB,
    ST_LDC,
    ST_MUL,
    ST_FIN,
    ST_UPD,
    ST_MMRD,
    ST_PUSH
  } state_t;

  localparam angle_t MIN_RESET = 24'sd2560000;
  localparam angle_t MAX_RESET = -24'sd2560000;
  localparam angle_t ANGLE_HI  = 24'sd8388607;
  localparam angle_t ANGLE_LO  = -24'sd8388608;

  localparam int BUILTIN_ROWS = 16;

  // Factory calibration rows: square, linear, offset terms, Q15.32
  localparam coef_t BUILTIN_COEF [BUILTIN_ROWS][3] = '{
    '{-48'sd375730, 48'sd2359251355, -48'sd3047022279377},
    '{ 48'sd185494, -48'sd1239663481, 48'sd2225909834415},
    '{ 48'sd351949, -48'sd2092316734, 48'sd3235035125212},
    '{ 48'sd125841, -48'sd1013434743, 48'sd2035352528931},
    '{-48'sd22713,  48'sd520801693,  -48'sd632416332011},
    '{-48'sd583868, 48'sd3510948449, -48'sd4437101664923},
    '{ 48'sd436555, -48'sd2777624370, 48'sd4432284965806},
    '{-48'sd178132, 48'sd1183392141, -48'sd1267708088981},
    '{-48'sd668570, 48'sd3633892242, -48'sd4270577215352},
    '{ 48'sd731149, -48'sd4846699302, 48'sd7597590280952},
    '{-48'sd178132, 48'sd1183392141, -48'sd1267708088981},
    '{-48'sd668570, 48'sd3633892242, -48'sd4270577215352},
    '{ 48'sd731149, -48'sd4846699302, 48'sd7597590280952},
    '{-48'sd215422, 48'sd1323226915, -48'sd1398220544482},
    '{-48'sd879907, 48'sd5069086129, -48'sd6537248167048},
    '{ 48'sd387745, -48'sd2484600543, 48'sd3976940615577}
  };

  function automatic coef_t builtin_coef(input logic [MAX_CH_W-1:0] ch,
                                         input logic [1:0] slot);
    if (ch < MAX_CH_W'(BUILTIN_ROWS) && slot <= SLOT_OFS) begin
      return BUILTIN_COEF[ch[3:0]][slot];
    end
    return '0;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hall_sensor_angle_minmax_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake          Beat contents
// in       input      in_valid/in_ready  req_type, channel, sample, coef_slot, coef_value
// out      output     out_valid/out_ready out_channel, angle, min/max angle, calib_changed
//
// One request at a time. A conversion goes from acceptance to the result register
// through three coefficient reads from the table, four partial products through
// one 25x(2*SAMPLE_BITS+1) multiplier, rounding, then the min/max read-modify-write.
// Clear, coefficient write and out-of-range channel skip to the min/max read state.
// Reset restores the factory table and the min/max limits at once through valid bits.
// A result waiting on out_ready holds the last state; no new beat is taken meanwhile.
`include "hall_sensor_angle_minmax_tracker_macros.svh"

module hall_sensor_angle_minmax_tracker #(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [3:0]                    in_channel,
  input  wire logic [SAMPLE_BITS-1:0]        in_sample,
  input  wire logic [1:0]                    in_coef_slot,
  input  wire logic signed [hsat_pkg::COEF_W-1:0] in_coef_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [3:0]                         out_channel,
  output logic signed [hsat_pkg::ANGLE_W-1:0] out_angle,
  output logic signed [hsat_pkg::ANGLE_W-1:0] out_min_angle,
  output logic signed [hsat_pkg::ANGLE_W-1:0] out_max_angle,
  output logic                               out_calib_changed
);

  import hsat_pkg::*;

  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CA_W       = CH_W + 2;
  localparam int COEF_DEPTH = CHANNELS * 4;
  localparam int SQ_W       = 2 * SAMPLE_BITS;
  localparam int MA_W       = 25;
  localparam int MB_W       = SQ_W + 1;
  localparam int PR_W       = MA_W + MB_W;
  localparam int ACC_W      = COEF_W + SQ_W + 2;
  localparam int MM_W       = 2 * ANGLE_W;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << 23;

  // control
  state_t              state_r, state_nxt;
  logic [1:0]          step_r;
  logic                out_valid_r;
  logic                in_acc;
  logic                ch_ok_in;
  logic                conv_go;
  logic                out_load;
  logic                mm_rd_en;
  logic [1:0]          mul_sel;
  logic [CA_W-1:0]     coef_raddr;
  logic [CH_W-1:0]     in_ch_idx;

  // latched request
  logic [1:0]             req_r;
  logic [3:0]             ch_r;
  logic                   ch_ok_r;
  logic [SAMPLE_BITS-1:0] x_r;
  logic [CH_W-1:0]        ch_idx;

  // coefficient store
  coef_t                  coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0]  coef_vld_r;
  coef_t                  coef_q_r;
  logic                   coef_vld_q_r;
  logic [CA_W-1:0]        coef_addr_q_r;
  coef_t                  coef_rd;
  logic                   coef_we;

  // min/max store
  logic [MM_W-1:0]        mm_mem [CHANNELS];
  logic [CHANNELS-1:0]    mm_vld_r;
  logic [MM_W-1:0]        mm_q_r;
  logic                   mm_vld_q_r;
  angle_t                 mm_min, mm_max;
  logic                   mm_we;

  // arithmetic
  coef_t                     a_r, b_r;
  logic [SQ_W-1:0]           xsq_r;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PR_W-1:0]    prod_r;
  logic                      prod_shift_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   prod_ext;
  logic                      acc_fits;
  angle_t                    angle_sat;
  angle_t                    angle_r;
  logic                      below_min, above_max;
  angle_t                    upd_min, upd_max;

  // result
  angle_t res_angle_r, res_min_r, res_max_r;
  logic   res_changed_r;
  angle_t out_angle_r, out_min_r, out_max_r;
  logic   out_changed_r;
  logic [3:0] out_channel_r;

  assign in_ch_idx = CH_W'(in_channel);
  assign ch_idx    = CH_W'(ch_r);
  assign ch_ok_in  = int'(in_channel) < CHANNELS;
  assign in_acc    = in_valid && in_ready;
  assign conv_go   = (in_req_type == REQ_CONVERT) && ch_ok_in;
  assign coef_we   = in_acc && (in_req_type == REQ_WRITE) && ch_ok_in
                     && (in_coef_slot <= SLOT_OFS);
  assign mm_we     = (state_r == ST_UPD);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = conv_go ? ST_LDA : ST_MMRD;
      end
      ST_LDA:  state_nxt = ST_LDB;
      ST_LDB:  state_nxt = ST_LDC;
      ST_LDC:  state_nxt = ST_MUL;
      ST_MUL: begin
        if (step_r == 2'd3) state_nxt = ST_FIN;
      end
      ST_FIN:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_PUSH;
      ST_MMRD: state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    mm_rd_en   = 1'b0;
    mul_sel    = step_r + 2'd1;
    coef_raddr = {ch_idx, SLOT_SQ};
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        mm_rd_en   = 1'b1;
        coef_raddr = {in_ch_idx, SLOT_SQ};
      end
      ST_LDA:  coef_raddr = {ch_idx, SLOT_LIN};
      ST_LDB:  coef_raddr = {ch_idx, SLOT_OFS};
      ST_LDC:  mul_sel = 2'd0;
      ST_PUSH: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      coef_vld_r  <= '0;
      mm_vld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_r == ST_MUL) ? step_r + 2'd1 : 2'd0;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (coef_we) coef_vld_r[{in_ch_idx, in_coef_slot}] <= 1'b1;
      if (in_acc && in_req_type == REQ_CLEAR && ch_ok_in) begin
        mm_vld_r <= '0;
      end else if (mm_we) begin
        mm_vld_r[ch_idx] <= 1'b1;
      end
    end
  end

  // coefficient memory, one write on acceptance, one registered read per cycle
  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[{in_ch_idx, in_coef_slot}] <= in_coef_value;
    coef_q_r      <= coef_mem[coef_raddr];
    coef_vld_q_r  <= coef_vld_r[coef_raddr];
    coef_addr_q_r <= coef_raddr;
  end

  // entries never written fall back to the factory row
  assign coef_rd = coef_vld_q_r ? coef_q_r
                 : builtin_coef(MAX_CH_W'(coef_addr_q_r[CA_W-1:2]), coef_addr_q_r[1:0]);

  // min/max memory, read on acceptance, written back at update
  always_ff @(posedge clk) begin
    if (mm_we) mm_mem[ch_idx] <= {upd_min, upd_max};
    if (mm_rd_en) begin
      mm_q_r     <= mm_mem[in_ch_idx];
      mm_vld_q_r <= mm_vld_r[in_ch_idx];
    end
  end

  assign mm_min = mm_vld_q_r ? angle_t'(mm_q_r[MM_W-1:ANGLE_W]) : MIN_RESET;
  assign mm_max = mm_vld_q_r ? angle_t'(mm_q_r[ANGLE_W-1:0]) : MAX_RESET;

  // shared multiplier: coefficient halves against x*x or x
  always_comb begin
    unique case (mul_sel)
      2'd0: mul_a = signed'({1'b0, a_r[23:0]});
      2'd1: mul_a = signed'({a_r[COEF_W-1], a_r[COEF_W-1:24]});
      2'd2: mul_a = signed'({1'b0, b_r[23:0]});
      2'd3: mul_a = signed'({b_r[COEF_W-1], b_r[COEF_W-1:24]});
      default: mul_a = '0;
    endcase
    mul_b = mul_sel[1] ? signed'(MB_W'(x_r)) : signed'({1'b0, xsq_r});
  end

  assign prod_ext  = prod_shift_r ? (ACC_W'(prod_r) <<< 24) : ACC_W'(prod_r);
  assign acc_fits  = (&acc_r[ACC_W-1:ANGLE_W+23]) || !(|acc_r[ACC_W-1:ANGLE_W+23]);
  assign angle_sat = acc_fits ? angle_t'(acc_r[ANGLE_W+23:24])
                   : (acc_r[ACC_W-1] ? ANGLE_LO : ANGLE_HI);
  assign below_min = angle_r < mm_min;
  assign above_max = angle_r > mm_max;
  assign upd_min   = below_min ? angle_r : mm_min;
  assign upd_max   = (!below_min && above_max) ? angle_r : mm_max;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r   <= in_req_type;
      ch_r    <= in_channel;
      ch_ok_r <= ch_ok_in;
      x_r     <= in_sample;
    end
    if (state_r == ST_LDA) begin
      a_r   <= coef_rd;
      xsq_r <= x_r * x_r;
    end
    if (state_r == ST_LDB) b_r <= coef_rd;
    if (state_r == ST_LDC || state_r == ST_MUL) begin
      prod_r       <= mul_a * mul_b;
      prod_shift_r <= mul_sel[0];
    end
    // offset plus half an output LSB seeds the sum, then add the partial products
    if (state_r == ST_LDC) begin
      acc_r <= ACC_W'(coef_rd) + RND_HALF;
    end else if (state_r == ST_MUL) begin
      acc_r <= acc_r + prod_ext;
    end
    if (state_r == ST_FIN) angle_r <= angle_sat;
    if (state_r == ST_UPD) begin
      res_angle_r   <= angle_r;
      res_min_r     <= upd_min;
      res_max_r     <= upd_max;
      res_changed_r <= below_min || above_max;
    end
    if (state_r == ST_MMRD) begin
      res_angle_r   <= '0;
      res_changed_r <= 1'b0;
      if (!ch_ok_r) begin
        res_min_r <= '0;
        res_max_r <= '0;
      end else if (req_r == REQ_CLEAR) begin
        res_min_r <= MIN_RESET;
        res_max_r <= MAX_RESET;
      end else begin
        res_min_r <= mm_min;
        res_max_r <= mm_max;
      end
    end
    if (out_load) begin
      out_channel_r <= ch_r;
      out_angle_r   <= res_angle_r;
      out_min_r     <= res_min_r;
      out_max_r     <= res_max_r;
      out_changed_r <= res_changed_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = out_channel_r;
  assign out_angle         = out_angle_r;
  assign out_min_angle     = out_min_r;
  assign out_max_angle     = out_max_r;
  assign out_calib_changed = out_changed_r;

  `HSAT_ASSERT_IMP(a_changed_hits_limit, (state_r == ST_PUSH && res_changed_r), (res_min_r == res_angle_r || res_max_r == res_angle_r), "moved limit does not equal the angle")
  `HSAT_ASSERT_NXT(a_clear_all, (in_acc && in_req_type == REQ_CLEAR && ch_ok_in), (mm_vld_r == '0), "clear left a channel limit in place")
  `HSAT_ASSERT_NXT(a_busy_after_accept, in_acc, (state_r != ST_IDLE), "sequencer idle after taking a beat")
  `HSAT_ASSERT_IMP(a_bad_channel_zero, (state_r == ST_PUSH && !ch_ok_r), (res_angle_r == '0 && res_min_r == '0 && res_max_r == '0 && !res_changed_r), "out-of-range channel gave non-zero result")

endmodule

`default_nettype wire

// ===== tb/tb_hall_sensor_angle_minmax_tracker.sv =====
`timescale 1ns / 1ps

module tb_hall_sensor_angle_minmax_tracker;
  import hsat_pkg::*;

  localparam int     N_DIRECTED = 26;
  localparam int     N_PHASE    = 300;
  localparam int     LONG_HOLD  = 200;
  localparam coef_t  COEF_TOP   = 48'sh7FFF_FFFF_FFFF;
  localparam coef_t  COEF_BOT   = 48'sh8000_0000_0000;
  localparam coef_t  ONE_Q32    = 48'sh0001_0000_0000;
  localparam coef_t  ODD_BITS   = 48'sh5A5A_A5A5_0F0F;

  typedef struct packed {
    req_t        kind;
    logic [3:0]  ch;
    logic [11:0] sample;
    logic [1:0]  slot;
    coef_t       value;
  } sensor_req_t;

  typedef struct packed {
    logic [3:0] ch;
    angle_t     angle;
    angle_t     lo;
    angle_t     hi;
    logic       changed;
  } reading_t;

  typedef struct {
    req_t        kind;
    logic [3:0]  ch;
    logic [11:0] sample;
    logic [1:0]  slot;
    coef_t       value;
    bit          typed;
    angle_t      e_angle;
    angle_t      e_lo;
    angle_t      e_hi;
    logic        e_chg;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_req_type;
  logic [3:0]          in_channel;
  logic [11:0]         in_sample;
  logic [1:0]          in_coef_slot;
  logic signed [47:0]  in_coef_value;
  logic                out_valid;
  logic                out_ready;
  logic [3:0]          out_channel;
  logic signed [23:0]  out_angle;
  logic signed [23:0]  out_min_angle;
  logic signed [23:0]  out_max_angle;
  logic                out_calib_changed;

  hall_sensor_angle_minmax_tracker dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_channel        (in_channel),
    .in_sample         (in_sample),
    .in_coef_slot      (in_coef_slot),
    .in_coef_value     (in_coef_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel       (out_channel),
    .out_angle         (out_angle),
    .out_min_angle     (out_min_angle),
    .out_max_angle     (out_max_angle),
    .out_calib_changed (out_calib_changed)
  );

  // Own copy of the block's state
  coef_t    coef_tab [16][3];
  angle_t   min_tab [16];
  angle_t   max_tab [16];
  reading_t pending_readings [$];
  int       mismatches;
  int       snd_gap_pct;
  int       rcv_gap_pct;
  bit       long_hold_req;

  dir_row_t directed [N_DIRECTED] = '{
    '{REQ_NONE,    4'd0,  12'd0,    SLOT_SQ,  48'sd0,   1'b1, 24'sd0, MIN_RESET, MAX_RESET, 1'b0},
    '{REQ_CLEAR,   4'd15, 12'd0,    SLOT_SQ,  48'sd0,   1'b1, 24'sd0, MIN_RESET, MAX_RESET, 1'b0},
    '{REQ_CONVERT, 4'd0,  12'd0,    SLOT_SQ,  48'sd0,   1'b0, 24'sd0, 24'sd0, 24'sd0, 1'b0},
    '{REQ_CONVERT, 4'd0,  12'hFFF,  SLOT_SQ,  48'sd0,   1'b0, 24'sd0, 24'sd0, 24'sd0, 1'b0},
    '{REQ_CONVERT, 4'd9,  12'd2048, SLOT_SQ,  48'sd0,   1'b0, 24'sd0, 24'sd0, 24'sd0, 1'b0},
    '{REQ_CONVERT, 4'd14, 12'hFFF,  SLOT_SQ,  48'sd0,   1'b0, 24'sd0, 24'sd0, 24'sd0, 1'b0},
    '{REQ_WRITE,   4'd3,  12'd0,    SLOT_SQ,  48'sd0,   1'b1, 24'sd0, MIN_RESET, MAX_RESET, 1'b0},
    '{REQ_WRITE,   4'd3,  12'd0,    SLOT_LIN, 48'sd0,   1'b1, 24'sd0, MIN_RESET, MAX_RESET, 1'b0},
    '{REQ_WRITE,   4'd3,  12'd0,    SLOT_OFS, COEF_TOP, 1'b1, 24'sd0, MIN_RESET, MAX_RESET, 1'b0},
    '{REQ_CONVERT, 4'd3,  12'hFFF,  SLOT_SQ,  48'sd0,   1'b1, ANGLE_HI, MIN_RESET, ANGLE_HI, 1'b1},
    '{REQ_WRITE,   4'd3,  12'd0,    SLOT_OFS, COEF_BOT, 1'b1, 24'sd0, MIN_RESET, ANGLE_HI, 1'b0},
    '{REQ_CONVERT, 4'd3,  12'd0,    SLOT_SQ,  48'sd0,   1'b1, ANGLE_LO, ANGLE_LO, ANGLE_HI, 1'b1},
    '{REQ_WRITE,   4'd3,  12'd0,    2'd3,     ODD_BITS, 1'b1, 24'sd0, ANGLE_LO, ANGLE_HI, 1'b0},
    '{REQ_CONVERT, 4'd3,  12'd1,    SLOT_SQ,  48'sd0,   1'b1, ANGLE_LO, ANGLE_LO, ANGLE_HI, 1'b0},
    '{REQ_WRITE,   4'd3,  12'd0,    SLOT_SQ,  COEF_TOP, 1'b1, 24'sd0, ANGLE_LO, ANGLE_HI, 1'b0},
    '{REQ_CONVERT, 4'd3,  12'hFFF,  SLOT_SQ,  48'sd0,   1'b0, 24'sd0, 24'sd0, 24'sd0, 1'b0},
    '{REQ_WRITE,   4'd3,  12'd0,    SLOT_SQ,  COEF_BOT, 1'b1, 24'sd0, ANGLE_LO, ANGLE_HI, 1'b0},
    '{REQ_CONVERT, 4'd3,  12'hFFF,  SLOT_SQ,  48'sd0,   1'b0, 24'sd0, 24'sd0, 24'sd0, 1'b0},
    '{REQ_WRITE,   4'd7,  12'd0,    SLOT_SQ,  48'sd0,   1'b1, 24'sd0, MIN_RESET, MAX_RESET, 1'b0},
    '{REQ_WRITE,   4'd7,  12'd0,    SLOT_OFS, 48'sd0,   1'b1, 24'sd0, MIN_RESET, MAX_RESET, 1'b0},
    '{REQ_WRITE,   4'd7,  12'd0,    SLOT_LIN, ONE_Q32,  1'b1, 24'sd0, MIN_RESET, MAX_RESET, 1'b0},
    '{REQ_CONVERT, 4'd7,  12'd100,  SLOT_SQ,  48'sd0,   1'b1, 24'sd25600, 24'sd25600, MAX_RESET, 1'b1},
    '{REQ_CONVERT, 4'd7,  12'd200,  SLOT_SQ,  48'sd0,   1'b1, 24'sd51200, 24'sd25600, 24'sd51200, 1'b1},
    '{REQ_CONVERT, 4'd7,  12'd150,  SLOT_SQ,  48'sd0,   1'b1, 24'sd38400, 24'sd25600, 24'sd51200, 1'b0},
    '{REQ_CLEAR,   4'd3,  12'd0,    SLOT_SQ,  48'sd0,   1'b1, 24'sd0, MIN_RESET, MAX_RESET, 1'b0},
    '{REQ_NONE,    4'd3,  12'hFFF,  SLOT_OFS, COEF_TOP, 1'b1, 24'sd0, MIN_RESET, MAX_RESET, 1'b0}
  };

  function automatic void restore_limits();
    for (int c = 0; c < 16; c++) begin
      min_tab[c] = MIN_RESET;
      max_tab[c] = MAX_RESET;
    end
  endfunction

  // a*x*x + b*x + c in Q.32, round half up to Q.8, saturate
  function automatic angle_t linearise(input logic [3:0] ch, input logic [11:0] x);
    logic signed [95:0] xs;
    logic signed [95:0] acc;
    xs  = $signed({84'd0, x});
    acc = coef_tab[ch][SLOT_SQ] * (xs * xs) + coef_tab[ch][SLOT_LIN] * xs
        + coef_tab[ch][SLOT_OFS] + 96'sd8388608;
    acc = acc >>> 24;
    if (acc > ANGLE_HI) return ANGLE_HI;
    if (acc < ANGLE_LO) return ANGLE_LO;
    return angle_t'(acc[23:0]);
  endfunction

  function automatic reading_t predict_reading(input sensor_req_t b);
    reading_t r;
    r = '{b.ch, 24'sd0, 24'sd0, 24'sd0, 1'b0};
    case (b.kind)
      REQ_CONVERT: begin
        r.angle = linearise(b.ch, b.sample);
        if (r.angle < min_tab[b.ch]) begin
          min_tab[b.ch] = r.angle;
          r.changed = 1'b1;
        end else if (r.angle > max_tab[b.ch]) begin
          max_tab[b.ch] = r.angle;
          r.changed = 1'b1;
        end
      end
      REQ_CLEAR: restore_limits();
      REQ_WRITE: begin
        if (b.slot <= SLOT_OFS) coef_tab[b.ch][b.slot] = b.value;
      end
      default: ;
    endcase
    r.lo = min_tab[b.ch];
    r.hi = max_tab[b.ch];
    return r;
  endfunction

  function automatic sensor_req_t random_request();
    sensor_req_t b;
    coef_t       base;
    logic [1:0]  row_slot;
    int          pick;
    pick     = $urandom_range(0, 99);
    b.ch     = 4'($urandom_range(0, 15));
    b.sample = 12'($urandom);
    b.slot   = 2'($urandom);
    b.value  = coef_t'({$urandom, $urandom});
    if (pick < 75) begin
      b.kind = REQ_CONVERT;
      if ($urandom_range(0, 9) == 0) b.sample = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    end else if (pick < 95) begin
      b.kind = REQ_WRITE;
      if ($urandom_range(0, 9) == 0) b.slot = 2'd3;
      else b.slot = 2'($urandom_range(0, 2));
      // keep most writes near a plausible calibration so angles stay in range
      if ($urandom_range(0, 3) != 0) begin
        row_slot = (b.slot > SLOT_OFS) ? SLOT_OFS : b.slot;
        base     = BUILTIN_COEF[$urandom_range(0, 15)][row_slot];
        b.value  = base + (base >>> $urandom_range(3, 9)) * ($urandom_range(0, 1) ? 1 : -1);
      end
    end else if (pick < 97) begin
      b.kind = REQ_NONE;
    end else begin
      b.kind = REQ_CLEAR;
    end
    return b;
  endfunction

  task automatic offer_request(input sensor_req_t b, input bit typed, input reading_t typed_r);
    reading_t r;
    if ($urandom_range(0, 99) < snd_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_gap_pct);
    end
    in_valid      <= 1'b1;
    in_req_type   <= b.kind;
    in_channel    <= b.ch;
    in_sample     <= b.sample;
    in_coef_slot  <= b.slot;
    in_coef_value <= b.value;
    do @(posedge clk); while (!in_ready);
    r = predict_reading(b);
    pending_readings.push_back(typed ? typed_r : r);
  endtask

  // Hold the input until every pending reading has come back
  task automatic drain_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  function automatic bit field_ok(input string fname, input longint e, input longint a);
    if (e == a) return 1'b1;
    $display("%0t: %s expected %0d, got %0d", $time, fname, e, a);
    return 1'b0;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rcv_gap_pct);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    reading_t e;
    bit       ok;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: reading on channel %0d with nothing pending", $time, out_channel);
        mismatches++;
      end else begin
        e  = pending_readings.pop_front();
        ok = field_ok("channel", e.ch, out_channel);
        ok = field_ok("angle", e.angle, out_angle) && ok;
        ok = field_ok("min_angle", e.lo, out_min_angle) && ok;
        ok = field_ok("max_angle", e.hi, out_max_angle) && ok;
        ok = field_ok("calib_changed", e.changed, out_calib_changed) && ok;
        if (!ok) mismatches++;
      end
    end
  end

  initial begin
    sensor_req_t b;
    reading_t    t;
    mismatches    = 0;
    long_hold_req = 1'b0;
    snd_gap_pct   = 12;
    rcv_gap_pct   = 54;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_CONVERT;
    in_channel    <= '0;
    in_sample     <= '0;
    in_coef_slot  <= SLOT_SQ;
    in_coef_value <= '0;
    for (int c = 0; c < 16; c++)
      for (int k = 0; k < 3; k++) coef_tab[c][k] = BUILTIN_COEF[c][k];
    restore_limits();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      b = '{directed[i].kind, directed[i].ch, directed[i].sample, directed[i].slot,
            directed[i].value};
      t = '{directed[i].ch, directed[i].e_angle, directed[i].e_lo, directed[i].e_hi,
            directed[i].e_chg};
      offer_request(b, directed[i].typed, t);
    end

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        snd_gap_pct = 54;
        rcv_gap_pct = 12;
      end else if (phase == 2) begin
        snd_gap_pct = 0;
        rcv_gap_pct = 0;
        // stall the output while requests keep coming, so the input backs up
        long_hold_req = 1'b1;
      end
      for (int k = 0; k < N_PHASE; k++) offer_request(random_request(), 1'b0, t);
      drain_readings();
    end

    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/hsat_pkg.sv
hw/rtl/hall_sensor_angle_minmax_tracker.sv
tb/tb_hall_sensor_angle_minmax_tracker.sv
